// ----- rtl/lpfs_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the LED frame packer.
`default_nettype none

package lpfs_pkg;

  localparam int CHANNELS    = 16;
  localparam int IDX_W       = $clog2(CHANNELS);
  localparam int GRAY_GROUPS = CHANNELS / 2;
  localparam int CORR_GROUPS = CHANNELS / 4;
  localparam int GRP_W       = (GRAY_GROUPS > 1) ? $clog2(GRAY_GROUPS) : 1;
  localparam int GRAY_W      = 12;
  localparam int CORR_W      = 6;
  localparam int ACC_W       = 16;
  localparam int CNT_W       = 5;

  typedef enum logic [2:0] {
    OP_SET_GRAY     = 3'd0,
    OP_SET_ALL_GRAY = 3'd1,
    OP_READ_GRAY    = 3'd2,
    OP_UPD_GRAY     = 3'd3,
    OP_SET_CORR     = 3'd4,
    OP_SET_ALL_CORR = 3'd5,
    OP_UPD_CORR     = 3'd6,
    OP_FRAME_TICK   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    KIND_GRAY_BYTE  = 3'd0,
    KIND_CORR_BYTE  = 3'd1,
    KIND_GRAY_LATCH = 3'd2,
    KIND_CORR_LATCH = 3'd3,
    KIND_READ       = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_GRAY   = 2'd1,
    ST_CORR   = 2'd2,
    ST_CLATCH = 2'd3
  } state_t;

  localparam logic [1:0] GRAY_LAST_PHASE = 2'd2;
  localparam logic [1:0] CORR_LAST_PHASE = 2'd3;

  typedef struct packed {
    logic wr_gray;
    logic wr_all_gray;
    logic wr_corr;
    logic wr_all_corr;
    logic rd_gray;
    logic init;
    logic run_gray;
    logic run_corr;
    logic emit_glatch;
    logic emit_clatch;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       gray_last;
    logic       corr_last;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/lpfs_ctrl.sv -----
// Controller state machine: decodes commands and sequences the update streams.
`default_nettype none

module lpfs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [2:0]     opcode,
  input  wire lpfs_pkg::stat_t stat,
  output lpfs_pkg::cmd_t      cmd,
  output logic                busy
);

  lpfs_pkg::state_t state, state_next;
  logic             latch_pending, latch_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lpfs_pkg::ST_IDLE;
      latch_pending <= 1'b0;
    end else begin
      state         <= state_next;
      latch_pending <= latch_pending_next;
    end
  end

  always_comb begin
    state_next         = state;
    latch_pending_next = latch_pending;
    cmd                = '0;
    busy               = 1'b1;
    case (state)
      lpfs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (lpfs_pkg::op_t'(opcode))
            lpfs_pkg::OP_SET_GRAY:     cmd.wr_gray     = 1'b1;
            lpfs_pkg::OP_SET_ALL_GRAY: cmd.wr_all_gray = 1'b1;
            lpfs_pkg::OP_READ_GRAY: begin
              cmd.rd_gray = 1'b1;
              cmd.last    = 1'b1;
            end
            lpfs_pkg::OP_UPD_GRAY: begin
              cmd.init           = 1'b1;
              latch_pending_next = 1'b1;
              state_next         = lpfs_pkg::ST_GRAY;
            end
            lpfs_pkg::OP_SET_CORR:     cmd.wr_corr     = 1'b1;
            lpfs_pkg::OP_SET_ALL_CORR: cmd.wr_all_corr = 1'b1;
            lpfs_pkg::OP_UPD_CORR: begin
              cmd.init   = 1'b1;
              state_next = lpfs_pkg::ST_CORR;
            end
            lpfs_pkg::OP_FRAME_TICK: begin
              if (latch_pending) begin
                cmd.emit_glatch    = 1'b1;
                cmd.last           = 1'b1;
                latch_pending_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      lpfs_pkg::ST_GRAY: begin
        cmd.run_gray = 1'b1;
        if (stat.phase == lpfs_pkg::GRAY_LAST_PHASE && stat.gray_last) begin
          cmd.last   = 1'b1;
          state_next = lpfs_pkg::ST_IDLE;
        end
      end
      lpfs_pkg::ST_CORR: begin
        cmd.run_corr = 1'b1;
        if (stat.phase == lpfs_pkg::CORR_LAST_PHASE && stat.corr_last) begin
          state_next = lpfs_pkg::ST_CLATCH;
        end
      end
      lpfs_pkg::ST_CLATCH: begin
        cmd.emit_clatch = 1'b1;
        cmd.last        = 1'b1;
        state_next      = lpfs_pkg::ST_IDLE;
      end
      default: state_next = lpfs_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lpfs_dp.sv -----
// Datapath: level registers, read port, bit accumulator packer and result register.
`default_nettype none

module lpfs_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lpfs_pkg::cmd_t  cmd,
  input  wire logic [7:0]      channel,
  input  wire logic [15:0]     value,
  output lpfs_pkg::stat_t      stat,
  output logic                 strobe,
  output logic [2:0]           kind,
  output logic [11:0]          data,
  output logic                 last
);

  logic [lpfs_pkg::GRAY_W-1:0] gray [lpfs_pkg::CHANNELS];
  logic [lpfs_pkg::CORR_W-1:0] corr [lpfs_pkg::CHANNELS];

  logic [lpfs_pkg::IDX_W-1:0]  ptr;
  logic [1:0]                  phase;
  logic [lpfs_pkg::GRP_W-1:0]  grp;
  logic [lpfs_pkg::ACC_W-1:0]  acc;
  logic [lpfs_pkg::CNT_W-1:0]  cnt;

  logic                        ch_ok;
  logic [lpfs_pkg::IDX_W-1:0]  ch_idx;
  logic [lpfs_pkg::IDX_W-1:0]  rd_idx;
  logic [lpfs_pkg::GRAY_W-1:0] gray_rd;
  logic [lpfs_pkg::CORR_W-1:0] corr_rd;
  logic                        load_gray;
  logic                        load_corr;
  logic [lpfs_pkg::CNT_W-1:0]  load_w;
  logic [lpfs_pkg::GRAY_W-1:0] lvl;
  logic [lpfs_pkg::ACC_W-1:0]  acc_sum;
  logic [lpfs_pkg::CNT_W-1:0]  cnt_sum;
  logic [lpfs_pkg::CNT_W-1:0]  shamt;
  logic                        emit_byte;
  logic [7:0]                  byte_val;
  logic                        running;
  logic                        strobe_next;
  logic                        group_done;

  assign ch_ok   = channel < 8'(lpfs_pkg::CHANNELS);
  assign ch_idx  = channel[lpfs_pkg::IDX_W-1:0];
  assign rd_idx  = cmd.rd_gray ? ch_idx : ptr;
  assign gray_rd = gray[rd_idx];
  assign corr_rd = corr[ptr];

  assign load_gray = cmd.run_gray && (phase != lpfs_pkg::GRAY_LAST_PHASE);
  assign load_corr = cmd.run_corr;

  always_comb begin
    if (load_gray) begin
      load_w = lpfs_pkg::CNT_W'(lpfs_pkg::GRAY_W);
      lvl    = gray_rd;
    end else if (load_corr) begin
      load_w = lpfs_pkg::CNT_W'(lpfs_pkg::CORR_W);
      lvl    = lpfs_pkg::GRAY_W'(corr_rd);
    end else begin
      load_w = '0;
      lvl    = '0;
    end
  end

  // The accumulator keeps the unsent bits in its low cnt positions, oldest bit highest.
  assign acc_sum   = (acc << load_w) | lpfs_pkg::ACC_W'(lvl);
  assign cnt_sum   = cnt + load_w;
  assign emit_byte = cnt_sum >= lpfs_pkg::CNT_W'(8);
  assign shamt     = cnt_sum - lpfs_pkg::CNT_W'(8);
  assign byte_val  = 8'(acc_sum >> shamt);

  assign running     = cmd.run_gray || cmd.run_corr;
  assign strobe_next = cmd.rd_gray || cmd.emit_glatch || cmd.emit_clatch ||
                       (running && emit_byte);
  assign group_done  = (cmd.run_gray && phase == lpfs_pkg::GRAY_LAST_PHASE) ||
                       (cmd.run_corr && phase == lpfs_pkg::CORR_LAST_PHASE);

  assign stat.phase     = phase;
  assign stat.gray_last = grp == lpfs_pkg::GRP_W'(lpfs_pkg::GRAY_GROUPS - 1);
  assign stat.corr_last = grp == lpfs_pkg::GRP_W'(lpfs_pkg::CORR_GROUPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lpfs_pkg::CHANNELS; i++) begin
        gray[i] <= '0;
        corr[i] <= '1;
      end
    end else begin
      if (cmd.wr_gray && ch_ok) begin
        gray[ch_idx] <= value[lpfs_pkg::GRAY_W-1:0];
      end
      if (cmd.wr_corr && ch_ok) begin
        corr[ch_idx] <= value[lpfs_pkg::CORR_W-1:0];
      end
      for (int i = 0; i < lpfs_pkg::CHANNELS; i++) begin
        if (cmd.wr_all_gray) begin
          gray[i] <= value[lpfs_pkg::GRAY_W-1:0];
        end
        if (cmd.wr_all_corr) begin
          corr[i] <= value[lpfs_pkg::CORR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      phase  <= '0;
      grp    <= '0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (cmd.init) begin
        ptr   <= lpfs_pkg::IDX_W'(lpfs_pkg::CHANNELS - 1);
        phase <= '0;
        grp   <= '0;
        cnt   <= '0;
      end else if (running) begin
        cnt <= emit_byte ? shamt : cnt_sum;
        if (load_gray || load_corr) begin
          ptr <= ptr - 1'b1;
        end
        if (group_done) begin
          phase <= '0;
          grp   <= grp + 1'b1;
        end else begin
          phase <= phase + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      acc <= acc_sum;
    end
    last <= cmd.last;
    if (cmd.rd_gray) begin
      kind <= lpfs_pkg::KIND_READ;
      data <= ch_ok ? gray_rd : '0;
    end else if (cmd.emit_glatch) begin
      kind <= lpfs_pkg::KIND_GRAY_LATCH;
      data <= '0;
    end else if (cmd.emit_clatch) begin
      kind <= lpfs_pkg::KIND_CORR_LATCH;
      data <= '0;
    end else if (cmd.run_corr) begin
      kind <= lpfs_pkg::KIND_CORR_BYTE;
      data <= 12'(byte_val);
    end else begin
      kind <= lpfs_pkg::KIND_GRAY_BYTE;
      data <= 12'(byte_val);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/led_pwm_frame_serializer_core.sv -----
// Top level of the LED grayscale and correction frame packer.
//
//   Channel   Signals                          Direction  Handshake
//   command   opcode, channel, value           in         start high, busy low
//   result    kind, data, last                 out        strobe, one cycle each
//
// Level writes, reads and frame ticks leave busy low; the next command is taken
// in the following cycle. A result is registered and appears in the cycle
// after its command. A grayscale update keeps busy high while it sends one
// byte per cycle. A correction update keeps busy high while the packer reads
// one 6-bit level per cycle, and its final busy cycle sends the latch pulse.
// Reset sets grayscale levels to 0, correction levels to 63 and clears the
// pending latch. Results cannot be held off by the receiver.
`default_nettype none

module led_pwm_frame_serializer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  channel,
  input  wire logic [15:0] value,
  output logic             strobe,
  output logic [2:0]       kind,
  output logic [11:0]      data,
  output logic             last
);

  lpfs_pkg::cmd_t  cmd;
  lpfs_pkg::stat_t stat;

  lpfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  lpfs_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .channel (channel),
    .value   (value),
    .stat    (stat),
    .strobe  (strobe),
    .kind    (kind),
    .data    (data),
    .last    (last)
  );

  a_single_beats_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == lpfs_pkg::KIND_READ || kind == lpfs_pkg::KIND_GRAY_LATCH ||
               kind == lpfs_pkg::KIND_CORR_LATCH) |-> last)
    else $error("read or latch beat without last");

  a_latch_data_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == lpfs_pkg::KIND_GRAY_LATCH || kind == lpfs_pkg::KIND_CORR_LATCH)
      |-> data == 12'd0)
    else $error("latch pulse with nonzero data");

  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == lpfs_pkg::KIND_GRAY_BYTE || kind == lpfs_pkg::KIND_CORR_BYTE)
      |-> data[11:8] == 4'd0)
    else $error("serial byte wider than eight bits");

  a_update_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == lpfs_pkg::OP_UPD_GRAY || opcode == lpfs_pkg::OP_UPD_CORR)
      |=> busy)
    else $error("update did not start streaming");

endmodule

`default_nettype wire
